// ===== rtl/xcbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC block sender package
// Shared types, protocol bytes, status codes and the CRC-16 byte fold.
// ----------------------------------------------------------------------------
package xcbs_pkg;

    localparam int BLOCK_BYTES_DEF = 128;

    // Protocol bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  PKT_NUM_INIT = 8'h01;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_PEER = 2'd1;
    localparam logic [1:0] STATUS_SEQ  = 2'd2;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_PEER  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_DATA  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    // Link phase, one-hot
    typedef enum logic [6:0] {
        PH_WAIT_C   = 7'b0000001,
        PH_IDLE     = 7'b0000010,
        PH_PAYLOAD  = 7'b0000100,
        PH_WAIT_ACK = 7'b0001000,
        PH_DONE     = 7'b0010000,
        PH_ERR_PEER = 7'b0100000,
        PH_ERR_SEQ  = 7'b1000000
    } phase_t;

    // Results caused by one item: one result, or three bytes
    typedef struct packed {
        logic       tx_valid;
        logic       multi;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] status;
    } group_t;

    // Fold one byte into the CRC-16, MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/xcbs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC sender protocol core
// Holds the link state and turns one accepted item into its result group.
// ----------------------------------------------------------------------------
module xcbs_core #(
    parameter int BLOCK_BYTES = xcbs_pkg::BLOCK_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [1:0]          op,
    input  logic [7:0]          byte_in,
    input  logic [7:0]          block_length,
    output xcbs_pkg::group_t    group
);

    localparam logic [7:0] MAX_LEN = 8'(BLOCK_BYTES);

    xcbs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       pkt_num_reg, pkt_num_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       left_reg, left_next;

    logic [15:0]      crc_fold_val;
    logic [7:0]       left_dec;
    logic [7:0]       len_sat;

    assign crc_fold_val = xcbs_pkg::crc_fold(crc_reg, byte_in);
    assign left_dec     = left_reg - 8'd1;

    always_comb begin
        if (block_length == 8'd0) begin
            len_sat = 8'd1;
        end else if (block_length > MAX_LEN) begin
            len_sat = MAX_LEN;
        end else begin
            len_sat = block_length;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        pkt_num_next   = pkt_num_reg;
        crc_next       = crc_reg;
        left_next      = left_reg;
        group.tx_valid = 1'b0;
        group.multi    = 1'b0;
        group.byte0    = 8'h00;
        group.byte1    = 8'h00;
        group.byte2    = 8'h00;

        if (phase_reg != xcbs_pkg::PH_ERR_PEER && phase_reg != xcbs_pkg::PH_ERR_SEQ) begin
            unique case (xcbs_pkg::op_t'(op))
                xcbs_pkg::OP_PEER: begin
                    if (phase_reg == xcbs_pkg::PH_WAIT_C && byte_in == xcbs_pkg::BYTE_C) begin
                        phase_next = xcbs_pkg::PH_IDLE;
                    end else if (phase_reg == xcbs_pkg::PH_WAIT_ACK &&
                                 byte_in == xcbs_pkg::BYTE_ACK) begin
                        pkt_num_next = pkt_num_reg + 8'd1;
                        phase_next   = xcbs_pkg::PH_IDLE;
                    end else begin
                        phase_next = xcbs_pkg::PH_ERR_PEER;
                    end
                end
                xcbs_pkg::OP_BEGIN: begin
                    if (phase_reg != xcbs_pkg::PH_IDLE) begin
                        phase_next = xcbs_pkg::PH_ERR_SEQ;
                    end else begin
                        left_next      = len_sat;
                        crc_next       = xcbs_pkg::CRC_INIT;
                        phase_next     = xcbs_pkg::PH_PAYLOAD;
                        group.tx_valid = 1'b1;
                        group.multi    = 1'b1;
                        group.byte0    = xcbs_pkg::BYTE_SOH;
                        group.byte1    = pkt_num_reg;
                        group.byte2    = 8'hFF - len_sat;
                    end
                end
                xcbs_pkg::OP_DATA: begin
                    if (phase_reg != xcbs_pkg::PH_PAYLOAD || left_reg == 8'd0) begin
                        phase_next = xcbs_pkg::PH_ERR_SEQ;
                    end else begin
                        crc_next       = crc_fold_val;
                        left_next      = left_dec;
                        group.tx_valid = 1'b1;
                        group.byte0    = byte_in;
                        if (left_dec == 8'd0) begin
                            // block complete: append CRC, low byte first
                            phase_next  = xcbs_pkg::PH_WAIT_ACK;
                            group.multi = 1'b1;
                            group.byte1 = crc_fold_val[7:0];
                            group.byte2 = crc_fold_val[15:8];
                        end
                    end
                end
                xcbs_pkg::OP_END: begin
                    if (phase_reg != xcbs_pkg::PH_IDLE) begin
                        phase_next = xcbs_pkg::PH_ERR_SEQ;
                    end else begin
                        phase_next     = xcbs_pkg::PH_DONE;
                        group.tx_valid = 1'b1;
                        group.byte0    = xcbs_pkg::BYTE_EOT;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (phase_next == xcbs_pkg::PH_ERR_PEER) begin
            group.status = xcbs_pkg::STATUS_PEER;
        end else if (phase_next == xcbs_pkg::PH_ERR_SEQ) begin
            group.status = xcbs_pkg::STATUS_SEQ;
        end else begin
            group.status = xcbs_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= xcbs_pkg::PH_WAIT_C;
            pkt_num_reg <= xcbs_pkg::PKT_NUM_INIT;
            crc_reg     <= xcbs_pkg::CRC_INIT;
            left_reg    <= 8'd0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            pkt_num_reg <= pkt_num_next;
            crc_reg     <= crc_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ===== rtl/xcbs_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC sender result serializer
// Registers one result group and hands it out one result per transfer.
// ----------------------------------------------------------------------------
module xcbs_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  xcbs_pkg::group_t group_in,
    output logic             in_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_tx_valid,
    output logic [7:0]       m_tx_byte,
    output logic [1:0]       m_status,
    output logic             m_last
);

    localparam logic [1:0] IDX_LAST = 2'd2;

    xcbs_pkg::group_t group_reg;
    logic [1:0]       idx_reg;
    logic             valid_reg;
    logic             last_now;

    assign last_now = group_reg.multi ? (idx_reg == IDX_LAST) : 1'b1;
    // free when empty or when the final result leaves this cycle
    assign in_ready = !valid_reg || (m_ready && last_now);

    assign m_valid    = valid_reg;
    assign m_tx_valid = group_reg.tx_valid;
    assign m_status   = group_reg.status;
    assign m_last     = last_now;

    always_comb begin
        case (idx_reg)
            2'd0:    m_tx_byte = group_reg.byte0;
            2'd1:    m_tx_byte = group_reg.byte1;
            default: m_tx_byte = group_reg.byte2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            if (last_now) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            group_reg <= group_in;
        end
    end

endmodule

// ===== rtl/xmodem_crc_block_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC block sender
// Builds XMODEM-CRC blocks (SOH, packet number, length complement, payload,
// CRC-16) from a stream of items and reports protocol errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one item per transfer. s_op selects partner byte,
//   begin block, payload byte or end of transfer; s_byte_in and
//   s_block_length carry the operands.
//   Result channel (m_*): one result per transfer, m_last marks the final
//   result of an item. An item yields either one result or three (begin
//   block: SOH, packet number, 255 - length; last payload byte: the byte,
//   CRC low, CRC high).
//   The first result of an item is registered and shows in the cycle after its transfer.
//   Throughput: one item per cycle for single-result items while m_ready stays high;
//   a three-result item holds the output register until its final result is transferred,
//   so the item rate is then set by the one-result-per-cycle output port.
//   The next item is taken in the same cycle the final result of the
//   previous one is transferred.
//   Reset: the link waits for 'C', packet number 1, CRC 0, output empty.
//   Receiver stall: m_ready low holds the current result; s_ready drops
//   until the final result of the held group leaves.
// ----------------------------------------------------------------------------
module xmodem_crc_block_sender #(
    parameter int BLOCK_BYTES = xcbs_pkg::BLOCK_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_byte_in,
    input  logic [7:0] s_block_length,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic [1:0] m_status,
    output logic       m_last
);

    xcbs_pkg::group_t group;
    logic             fire;

    // advance link state only on an input transfer
    assign fire = s_valid && s_ready;

    xcbs_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .op           (s_op),
        .byte_in      (s_byte_in),
        .block_length (s_block_length),
        .group        (group)
    );

    // hold the result group and drain it one transfer at a time
    xcbs_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .group_in   (group),
        .in_ready   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_valid (m_tx_valid),
        .m_tx_byte  (m_tx_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

// ===== rtl/xcbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC sender port checker
// Watches the top-level ports for result-channel consistency.
// ----------------------------------------------------------------------------
module xcbs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic [1:0] m_status,
    input logic       m_last
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_last))
        else $error("result changed while stalled");

    // an accepted item shows a result in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transfer");

    // a result without a byte is alone and carries zero
    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_last && (m_tx_byte == 8'h00))
        else $error("empty result malformed");

    // an error status never comes with a transmit byte
    a_err_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != xcbs_pkg::STATUS_OK) |-> !m_tx_valid)
        else $error("byte sent with error status");

    // input taken only when the final pending result leaves or none pends
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_ready && m_last)
        else $error("input taken while results pending");

endmodule

bind xmodem_crc_block_sender xcbs_checker u_xcbs_checker (.*);
